// ===== rtl/core/tdpt_pkg.sv =====
package tdpt_pkg;

    localparam int DATA_WIDTH = 32;
    // divisor, squared divisor, partial remainder and bit counter widths
    localparam int DIV_W = DATA_WIDTH / 2 + 1;
    localparam int SQ_W  = DATA_WIDTH + 1;
    localparam int REM_W = DATA_WIDTH / 2 + 2;
    localparam int CNT_W = $clog2(DATA_WIDTH);

    localparam logic [DIV_W-1:0]      FIRST_DIV   = DIV_W'(2);
    localparam logic [DIV_W-1:0]      SECOND_DIV  = DIV_W'(3);
    localparam logic [SQ_W-1:0]       FIRST_SQ    = SQ_W'(4);
    localparam logic [SQ_W-1:0]       SECOND_SQ   = SQ_W'(9);
    localparam logic [SQ_W-1:0]       SQ_STEP_ADD = SQ_W'(4);
    localparam logic [DIV_W-1:0]      DIV_STEP    = DIV_W'(2);
    localparam logic [DATA_WIDTH-1:0] SMALLEST_PRIME = DATA_WIDTH'(2);
    localparam logic [CNT_W-1:0]      LAST_BIT    = CNT_W'(DATA_WIDTH - 1);

    typedef struct packed {
        logic load;       // latch input value, restart divisor at two
        logic div_start;  // clear remainder, begin bit-serial reduction
        logic div_step;   // one restoring step of value mod divisor
        logic next_div;   // advance to the next candidate divisor
        logic res_we;     // write the output register
        logic res_val;
    } t_cmd;

    typedef struct packed {
        logic below_two;  // negative, zero or one
        logic bound_over; // divisor squared exceeds the value
        logic div_last;   // final remainder step in progress
        logic rem_zero;
    } t_status;

endpackage

// ===== rtl/core/tdpt_ctrl.sv =====
module tdpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tdpt_pkg::t_status i_status,
    output tdpt_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_DIV   = 5'b00100,
        S_TEST  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_res, n_res;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.below_two) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else if (i_status.bound_over) begin
                    n_res   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_TEST;
                end
            end
            S_TEST: begin
                if (i_status.rem_zero) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state        = S_CHECK;
                end
            end
            S_DONE: begin
                // hold the verdict until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.res_we  = 1'b1;
                    o_cmd.res_val = r_res;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.res_we) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

// ===== rtl/core/tdpt_dp.sv =====
module tdpt_dp (
    input  logic                                i_clk,
    input  logic signed [tdpt_pkg::DATA_WIDTH-1:0] i_value,
    input  tdpt_pkg::t_cmd                      i_cmd,
    output tdpt_pkg::t_status                   o_status,
    output logic                                o_is_prime
);

    logic [tdpt_pkg::DATA_WIDTH-1:0] r_value;
    logic [tdpt_pkg::DATA_WIDTH-1:0] r_shift;
    logic [tdpt_pkg::DIV_W-1:0]      r_div;
    logic [tdpt_pkg::SQ_W-1:0]       r_sq;
    logic [tdpt_pkg::REM_W-1:0]      r_rem;
    logic [tdpt_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_is_prime;

    logic [tdpt_pkg::REM_W-1:0]      rem_shifted;
    logic [tdpt_pkg::REM_W-1:0]      div_ext;
    logic [tdpt_pkg::REM_W-1:0]      rem_next;
    logic [tdpt_pkg::SQ_W-1:0]       sq_next;

    // remainder stays below the divisor, so one shifted-in bit keeps it below twice it
    assign rem_shifted = {r_rem[tdpt_pkg::REM_W-2:0], r_shift[tdpt_pkg::DATA_WIDTH-1]};
    assign div_ext     = tdpt_pkg::REM_W'(r_div);
    assign rem_next    = (rem_shifted >= div_ext) ? (rem_shifted - div_ext) : rem_shifted;

    // (d+2)^2 = d^2 + 4d + 4
    assign sq_next = r_sq + tdpt_pkg::SQ_W'({r_div, 2'b00}) + tdpt_pkg::SQ_STEP_ADD;

    assign o_status.below_two  = r_value[tdpt_pkg::DATA_WIDTH-1]
                               || (r_value < tdpt_pkg::SMALLEST_PRIME);
    assign o_status.bound_over = r_sq > tdpt_pkg::SQ_W'(r_value);
    assign o_status.div_last   = (r_cnt == '0);
    assign o_status.rem_zero   = (r_rem == '0);
    assign o_is_prime          = r_is_prime;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
            r_div   <= tdpt_pkg::FIRST_DIV;
            r_sq    <= tdpt_pkg::FIRST_SQ;
        end else if (i_cmd.next_div) begin
            // after two, only odd candidates can divide first
            if (r_div == tdpt_pkg::FIRST_DIV) begin
                r_div <= tdpt_pkg::SECOND_DIV;
                r_sq  <= tdpt_pkg::SECOND_SQ;
            end else begin
                r_div <= r_div + tdpt_pkg::DIV_STEP;
                r_sq  <= sq_next;
            end
        end

        if (i_cmd.div_start) begin
            r_rem   <= '0;
            r_shift <= r_value;
            r_cnt   <= tdpt_pkg::LAST_BIT;
        end else if (i_cmd.div_step) begin
            r_rem   <= rem_next;
            r_shift <= {r_shift[tdpt_pkg::DATA_WIDTH-2:0], 1'b0};
            r_cnt   <= r_cnt - 1'b1;
        end

        if (i_cmd.res_we) begin
            r_is_prime <= i_cmd.res_val;
        end
    end

endmodule

// ===== rtl/core/trial_division_prime_test.sv =====
// A value below two gets its verdict straight from the check; else divisors are tried in turn
// (2, then odd ones) until one divides the value or its square exceeds the value.
// The bit-serial remainder unit reduces the value by each divisor one bit at a time.
// Worst case for 32 bits (prime near 2^31): about 23170 divisors.
// One value in flight; the next is accepted once the verdict moves to the output register.
// Synchronous active-low reset clears the controller and the output valid flag.
module trial_division_prime_test (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [tdpt_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_is_prime
);

    tdpt_pkg::t_cmd    cmd;
    tdpt_pkg::t_status status;

    tdpt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    tdpt_dp u_dp (
        .i_clk      (i_clk),
        .i_value    (i_value),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_is_prime (o_is_prime)
    );

endmodule

// ===== rtl/core/tdpt_checker.sv =====
module tdpt_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_ready,
    input logic signed [tdpt_pkg::DATA_WIDTH-1:0] i_value,
    input logic                                   o_out_valid,
    input logic                                   i_out_ready,
    input logic                                   o_is_prime
);

    // a waiting result is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_is_prime))
        else $error("output payload changed while stalled");

    // one value at a time: ready drops right after an input transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second input taken while busy");

    // a new result only appears at the end of a test, never while idle
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result produced without a test in progress");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (.*);

// ===== test/prime_verdict_checker.sv =====
`timescale 1ns / 1ps

module prime_verdict_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic signed [tdpt_pkg::DATA_WIDTH-1:0] i_value,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic                                   i_is_prime,
    output int                                     o_mismatch_count,
    output int                                     o_pending
);

    typedef struct {
        logic signed [tdpt_pkg::DATA_WIDTH-1:0] value;
        logic                                   is_prime;
    } t_verdict;

    t_verdict verdict_fifo[$];
    int       mismatches = 0;

    function automatic logic prime_by_trial_division(
        input logic signed [tdpt_pkg::DATA_WIDTH-1:0] value
    );
        longint unsigned n;
        longint unsigned d;
        // signed compare: negatives, zero and one are never prime
        if (value < 2) return 1'b0;
        n = value;
        for (d = 2; d <= n / d; d++) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 10) $display("[%0t] checker: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_verdict head;
        if (i_rst_n) begin
            // retire before accepting so a stray result never matches a fresh value
            if (i_out_valid && i_out_ready) begin
                if (verdict_fifo.size() == 0) begin
                    report_mismatch($sformatf(
                        "result transaction with nothing outstanding: is_prime=%0b",
                        i_is_prime));
                end else begin
                    head = verdict_fifo.pop_front();
                    if (i_is_prime !== head.is_prime) begin
                        report_mismatch($sformatf(
                            "is_prime mismatch for value %0d: expected %0b, got %0b",
                            head.value, head.is_prime, i_is_prime));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                head.value    = i_value;
                head.is_prime = prime_by_trial_division(i_value);
                verdict_fifo.push_back(head);
            end
        end
        o_pending        <= verdict_fifo.size();
        o_mismatch_count <= mismatches;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT   = 10_000_000;
    localparam int RANDOM_ITEMS  = 68;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 4 * (tdpt_pkg::DATA_WIDTH + 2);

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_MOSTLY
    } t_stall_mode;

    logic                                   clk       = 1'b0;
    logic                                   rst_n     = 1'b0;
    logic                                   in_valid  = 1'b0;
    logic                                   in_ready;
    logic signed [tdpt_pkg::DATA_WIDTH-1:0] value     = '0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic                                   is_prime;

    int mismatch_count;
    int pending;
    int hold_requests = 0;
    int burst_left    = 0;

    always #4 clk = ~clk;

    trial_division_prime_test u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_value     (value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_is_prime  (is_prime)
    );

    prime_verdict_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_value          (value),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_is_prime       (is_prime),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // holds valid and payload until the transaction is taken
    task automatic send_value(input logic signed [tdpt_pkg::DATA_WIDTH-1:0] v);
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        // pending is a registered copy of the checker's queue size
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // most values stay small: latency grows with the square root of the value
    function automatic logic signed [tdpt_pkg::DATA_WIDTH-1:0] random_value();
        logic [tdpt_pkg::DATA_WIDTH-1:0] r;
        r = $urandom;
        case ($urandom_range(0, 19))
            0, 1, 2: return {1'b1, r[tdpt_pkg::DATA_WIDTH-2:0]};
            3, 4, 5: return {1'b0, r[tdpt_pkg::DATA_WIDTH-2:1], 1'b0};
            6, 7: begin
                r[tdpt_pkg::DATA_WIDTH-1] = 1'b0;
                return r - r % 3;
            end
            8, 9:    return $urandom_range(0, 1 << 18);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // receiver: shifting stall patterns plus one long hold-off on request
    initial begin
        int          hold_left;
        int          span_left;
        int          holds_served;
        t_stall_mode mode;
        hold_left    = 0;
        span_left    = 0;
        holds_served = 0;
        mode         = READY_ALWAYS;
        while (!rst_n) @(posedge clk);
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = LONG_HOLD;
                out_ready <= 1'b0;
            end else begin
                if (span_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    span_left = $urandom_range(8, 64);
                end
                span_left--;
                case (mode)
                    READY_ALWAYS: out_ready <= 1'b1;
                    READY_COIN:   out_ready <= $urandom_range(0, 1);
                    READY_SPARSE: out_ready <= (span_left % 4 == 0);
                    default:      out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        logic signed [tdpt_pkg::DATA_WIDTH-1:0] directed_values[$];
        logic [tdpt_pkg::DATA_WIDTH-1:0]        r;

        directed_values = '{
            0, 1, 2, 3, 4, 5, 7, 8, 9, 25, 97, 121,
            -1, -2, 32'h8000_0000, 32'hAAAA_AAAA,
            32'h7FFF_FFFF,            // largest prime of the field, slowest case
            32'h7FFF_FFFE, 32'h7FFF_FFFD, 32'h5555_5554,
            65521, 65537, 1000003, 1000001
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_values[i]) begin
            send_value(directed_values[i]);
            pace_sender();
        end
        wait_drained();

        // long receiver hold-off with fast values so the block backs up
        hold_requests <= hold_requests + 1;
        repeat (8) begin
            r = $urandom;
            send_value(r[0] ? {1'b1, r[tdpt_pkg::DATA_WIDTH-2:0]}
                            : {r[tdpt_pkg::DATA_WIDTH-1:1], 1'b0});
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            send_value(random_value());
            if (i == RANDOM_ITEMS / 2) begin
                wait_drained();
            end else begin
                pace_sender();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
